/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the timer queue.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is low
`define SDTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion, checked through reset as well
`define SDTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/sdtq_pkg.sv */
// Types and constants of the sorted deadline timer queue.
// No dependencies; used by the modules and the checker.
package sdtq_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_SUMMARY  = 2'd3
  } kind_t;

  // Item commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TMO_EMPTY = -32'sd1;

  // One queue entry as held in the memory
  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] tag;
  } entry_t;

  // Write request from the controller to the memory
  typedef struct packed {
    logic   we;
    entry_t data;
  } mem_wr_t;

  // Controller sequence
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_RESP
  } state_t;

endpackage

/* hw/rtl/sdtq_if.sv */
// Valid/ready channel interfaces for the timer queue input and result words.
// Depends on nothing; widths follow the item fields.
interface sdtq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] now_ms;
  logic [31:0] delay_ms;
  logic [15:0] timer_tag;

  modport source (output valid, command, now_ms, delay_ms, timer_tag, input ready);
  modport sink   (input valid, command, now_ms, delay_ms, timer_tag, output ready);
endinterface

interface sdtq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        expired_tag;
  logic signed [31:0] next_timeout_ms;
  logic               last;

  modport source (output valid, kind, expired_tag, next_timeout_ms, last, input ready);
  modport sink   (input valid, kind, expired_tag, next_timeout_ms, last, output ready);
endinterface

/* hw/rtl/sdtq_mem.sv */
// Entry memory of the timer queue: one write port, one read port, read data
// registered. Depends on sdtq_pkg.
module sdtq_mem #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = 4
) (
  input  logic             clk,
  input  sdtq_pkg::mem_wr_t wr,
  input  logic [AW-1:0]    waddr,
  input  logic [AW-1:0]    raddr,
  output sdtq_pkg::entry_t rdata
);
  import sdtq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sdtq_ctrl.sv */
// Queue controller: circular head/count over the entry memory, sorted insert
// by scan and shift, expiry walk from the head, result register.
// Depends on sdtq_pkg, sdtq_if and the memory ports of sdtq_mem.
module sdtq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  sdtq_in_if.sink           in_chan,
  sdtq_out_if.source        out_chan,
  output sdtq_pkg::mem_wr_t wr,
  output logic [AW-1:0]     waddr,
  output logic [AW-1:0]     raddr,
  input  sdtq_pkg::entry_t  rdata
);
  import sdtq_pkg::*;

  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  // Captured item
  logic [63:0] now_r, now_nxt;
  logic [63:0] dl_r, dl_nxt;
  logic [15:0] tag_r, tag_nxt;

  // Pending result
  kind_t              res_kind_r, res_kind_nxt;
  logic [15:0]        res_tag_r, res_tag_nxt;
  logic signed [31:0] res_tmo_r, res_tmo_nxt;
  logic               res_last_r, res_last_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r;
  logic [15:0]        out_tag_r;
  logic signed [31:0] out_tmo_r;
  logic               out_last_r;
  logic               slot_free;
  logic               load_out;

  logic [CW-1:0] rd_off;
  logic [AW:0]   rd_sum, wr_sum, head_sum;
  logic [63:0]   ins_diff, tick_diff;
  logic          ins_after, tick_due;

  // Map logical offsets from the head to memory addresses
  always_comb begin
    rd_sum   = {1'b0, head_r} + (AW+1)'(rd_off);
    wr_sum   = {1'b0, head_r} + (AW+1)'(idx_r);
    head_sum = {1'b0, head_r} + (AW+1)'(1);
    raddr    = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : rd_sum[AW-1:0];
    waddr    = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];
  end

  // Deadline compares on the word just read
  always_comb begin
    ins_diff  = rdata.deadline - dl_r;
    ins_after = (ins_diff != 64'd0) && !ins_diff[63];
    tick_diff = rdata.deadline - now_r;
    tick_due  = (tick_diff == 64'd0) || tick_diff[63];
  end

  assign slot_free = !out_valid_r || out_chan.ready;

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    now_nxt      = now_r;
    dl_nxt       = dl_r;
    tag_nxt      = tag_r;
    res_kind_nxt = res_kind_r;
    res_tag_nxt  = res_tag_r;
    res_tmo_nxt  = res_tmo_r;
    res_last_nxt = res_last_r;
    rd_off       = '0;
    wr           = '0;
    load_out     = 1'b0;
    in_chan.ready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          now_nxt = in_chan.now_ms;
          dl_nxt  = in_chan.now_ms + {32'd0, in_chan.delay_ms};
          tag_nxt = in_chan.timer_tag;
          idx_nxt = '0;
          if (in_chan.command == CMD_TICK) begin
            state_nxt = ST_TICK_RD;
          end else if (count_r == DEPTH_C) begin
            res_kind_nxt = KIND_REJECTED;
            res_tag_nxt  = '0;
            res_tmo_nxt  = '0;
            res_last_nxt = 1'b1;
            state_nxt    = ST_RESP;
          end else begin
            state_nxt = ST_ADD_RD;
          end
        end
      end

      // Scan for the first entry later than the new deadline
      ST_ADD_RD: begin
        rd_off = idx_r;
        if (idx_r == count_r) begin
          pos_nxt   = count_r;
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_ADD_CMP;
        end
      end

      ST_ADD_CMP: begin
        if (ins_after) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = ST_SH_RD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_ADD_RD;
        end
      end

      // Move the tail up one slot, then drop the new word in the gap
      ST_SH_RD: begin
        rd_off = idx_r - CW'(1);
        if (idx_r == pos_r) begin
          wr.we          = 1'b1;
          wr.data.deadline = dl_r;
          wr.data.tag    = tag_r;
          count_nxt      = count_r + CW'(1);
          res_kind_nxt   = KIND_ACCEPTED;
          res_tag_nxt    = '0;
          res_tmo_nxt    = '0;
          res_last_nxt   = 1'b1;
          state_nxt      = ST_RESP;
        end else begin
          state_nxt = ST_SH_WR;
        end
      end

      ST_SH_WR: begin
        wr.we     = 1'b1;
        wr.data   = rdata;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = ST_SH_RD;
      end

      // Expiry walk from the head
      ST_TICK_RD: begin
        if (count_r == '0) begin
          res_kind_nxt = KIND_SUMMARY;
          res_tag_nxt  = '0;
          res_tmo_nxt  = TMO_EMPTY;
          res_last_nxt = 1'b1;
          state_nxt    = ST_RESP;
        end else begin
          state_nxt = ST_TICK_CMP;
        end
      end

      ST_TICK_CMP: begin
        res_tag_nxt = '0;
        res_tmo_nxt = '0;
        if (tick_due) begin
          res_kind_nxt = KIND_EXPIRED;
          res_tag_nxt  = rdata.tag;
          res_last_nxt = 1'b0;
          head_nxt     = (head_sum >= DEPTH_W) ? '0 : head_sum[AW-1:0];
          count_nxt    = count_r - CW'(1);
        end else begin
          res_kind_nxt = KIND_SUMMARY;
          res_last_nxt = 1'b1;
          res_tmo_nxt  = (tick_diff[62:31] != '0) ? INT_MAX : tick_diff[31:0];
        end
        state_nxt = ST_RESP;
      end

      // Hand the pending word to the result register
      ST_RESP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = res_last_r ? ST_IDLE : ST_TICK_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    dl_r       <= dl_nxt;
    tag_r      <= tag_nxt;
    res_kind_r <= res_kind_nxt;
    res_tag_r  <= res_tag_nxt;
    res_tmo_r  <= res_tmo_nxt;
    res_last_r <= res_last_nxt;
    if (load_out) begin
      out_kind_r <= res_kind_r;
      out_tag_r  <= res_tag_r;
      out_tmo_r  <= res_tmo_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.kind            = out_kind_r;
  assign out_chan.expired_tag     = out_tag_r;
  assign out_chan.next_timeout_ms = out_tmo_r;
  assign out_chan.last            = out_last_r;

endmodule

/* hw/rtl/sorted_deadline_timer_queue_top.sv */
// Channel    Dir  Handshake       Word
// in_chan    in   valid/ready     command, now_ms, delay_ms, timer_tag
// out_chan   out  valid/ready     kind, expired_tag, next_timeout_ms, last
//
// One item at a time; memory read data is registered.
// Add: compares entries from the head until one is later than the new deadline, then
//   moves each later entry up a slot and writes the new entry; a full queue rejects.
// Tick: one expired word per due timer from the head, then a summary (-1 when empty).
// A full result register stalls the controller; the input is taken only when idle.
// Reset (rst_n low, synchronous) empties the queue; memory contents are not cleared.
module sorted_deadline_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sdtq_in_if.sink    in_chan,
  sdtq_out_if.source out_chan
);
  import sdtq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mem_wr_t       wr;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  sdtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .wr       (wr),
    .waddr    (waddr),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  sdtq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

/* hw/rtl/sdtq_check.sv */
// Port-level checks of the timer queue result words, bound to the top level.
// Depends on sdtq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdtq_check (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [15:0]        expired_tag,
  input logic signed [31:0] next_timeout_ms,
  input logic               last
);
  import sdtq_pkg::*;

  // Hold a stalled result word
  `SDTQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(expired_tag) && $stable(last), "result word changed while stalled")

  // Only expiry words leave an item open
  `SDTQ_ASSERT(a_last_kind, clk, rst_n, out_valid && (kind != KIND_EXPIRED) |-> last, "non-expiry word without last")

  // Expiry words carry no timeout and never close an item
  `SDTQ_ASSERT(a_expired_word, clk, rst_n, out_valid && (kind == KIND_EXPIRED) |-> !last && (next_timeout_ms == 32'sd0), "malformed expiry word")

  // Summary timeout is non-negative or the empty mark
  `SDTQ_ASSERT(a_summary_tmo, clk, rst_n, out_valid && (kind == KIND_SUMMARY) |-> !next_timeout_ms[31] || (next_timeout_ms == TMO_EMPTY), "bad summary timeout")

  // Add results carry no tag
  `SDTQ_ASSERT(a_add_tag, clk, rst_n, out_valid && (kind == KIND_ACCEPTED || kind == KIND_REJECTED) |-> (expired_tag == 16'd0), "add result with tag")

endmodule

bind sorted_deadline_timer_queue_top sdtq_check u_sdtq_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .kind            (out_chan.kind),
  .expired_tag     (out_chan.expired_tag),
  .next_timeout_ms (out_chan.next_timeout_ms),
  .last            (out_chan.last)
);
